### rtl/cln_pkg.sv
// ----------------------------------------------------------------------------
// cln_pkg
// Shared types, codes and microcode program for the LCD nibble sequencer.
// ----------------------------------------------------------------------------
package cln_pkg;

    localparam int STEP_W = 5;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_MOVE = 2'd2,
        KIND_INIT = 2'd3
    } kind_t;

    // 7-bit row base registers on the config port, selected by paddr[2].
    localparam logic REG_FIRST_ROW  = 1'b0;
    localparam logic REG_SECOND_ROW = 1'b1;

    localparam logic [6:0] FIRST_ROW_RST  = 7'd0;
    localparam logic [6:0] SECOND_ROW_RST = 7'd64;

    localparam logic [STEP_W-1:0] STEP_BYTE = 5'd0;
    localparam logic [STEP_W-1:0] STEP_INIT = 5'd2;

    typedef enum logic [1:0] {
        NIB_CONST = 2'd0,
        NIB_HIGH  = 2'd1,
        NIB_LOW   = 2'd2
    } nib_sel_t;

    typedef struct packed {
        nib_sel_t   sel;
        logic [3:0] nib;
        logic [5:0] wait_ms;
        logic       data_nowait;  // zero wait when RS is data
        logic       last;
    } ctrl_word_t;

    typedef struct packed {
        logic [6:0] first_row_base;
        logic [6:0] second_row_base;
    } row_cfg_t;

    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        case (step)
            5'd0:    cw = '{NIB_HIGH,  4'h0, 6'd2,  1'b1, 1'b0};
            5'd1:    cw = '{NIB_LOW,   4'h0, 6'd0,  1'b0, 1'b1};
            5'd2:    cw = '{NIB_CONST, 4'h3, 6'd50, 1'b0, 1'b0};
            5'd3:    cw = '{NIB_CONST, 4'h3, 6'd10, 1'b0, 1'b0};
            5'd4:    cw = '{NIB_CONST, 4'h3, 6'd10, 1'b0, 1'b0};
            5'd5:    cw = '{NIB_CONST, 4'h2, 6'd10, 1'b0, 1'b0};
            5'd6:    cw = '{NIB_CONST, 4'h2, 6'd22, 1'b0, 1'b0};
            5'd7:    cw = '{NIB_CONST, 4'h8, 6'd0,  1'b0, 1'b0};
            5'd8:    cw = '{NIB_CONST, 4'h0, 6'd12, 1'b0, 1'b0};
            5'd9:    cw = '{NIB_CONST, 4'hC, 6'd0,  1'b0, 1'b0};
            5'd10:   cw = '{NIB_CONST, 4'h0, 6'd12, 1'b0, 1'b0};
            5'd11:   cw = '{NIB_CONST, 4'h6, 6'd0,  1'b0, 1'b0};
            5'd12:   cw = '{NIB_CONST, 4'h8, 6'd12, 1'b0, 1'b0};
            5'd13:   cw = '{NIB_CONST, 4'h0, 6'd0,  1'b0, 1'b0};
            5'd14:   cw = '{NIB_CONST, 4'h0, 6'd12, 1'b0, 1'b0};
            5'd15:   cw = '{NIB_CONST, 4'h1, 6'd0,  1'b0, 1'b0};
            5'd16:   cw = '{NIB_CONST, 4'h0, 6'd12, 1'b0, 1'b0};
            5'd17:   cw = '{NIB_CONST, 4'h2, 6'd0,  1'b0, 1'b0};
            5'd18:   cw = '{NIB_HIGH,  4'h0, 6'd22, 1'b0, 1'b0};
            5'd19:   cw = '{NIB_LOW,   4'h0, 6'd0,  1'b0, 1'b1};
            default: cw = '{NIB_CONST, 4'h0, 6'd0,  1'b0, 1'b1};
        endcase
        return cw;
    endfunction

endpackage

### rtl/char_lcd_nibble_sequencer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// HD44780-style 4-bit bus sequencer driven by a microcode table.
// ----------------------------------------------------------------------------
// Input channel (s_): one request per item; kind in s_tuser, operands in
// s_tdata. Result channel (m_): one enable strobe per item with RS level in
// m_tuser, nibble and wait in m_tdata, m_tlast on the final strobe.
// Commands, data bytes and cursor moves give 2 strobes, initialize gives 18.
// A request is first latched into the byte register; then the step counter
// walks the control table, one table step fetched per cycle unless the
// receiver stalls, and each step loads one strobe into the output register.
// s_tready is high whenever no request is in progress, including while the
// final strobe still sits in the output register.
// A receiver stall holds the output register and freezes the step counter.
// Reset (aresetn low, synchronous) drops m_tvalid, clears the sequencer
// and returns the row bases to 0 and 64. The APB port has no wait states.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // value[7:0], column[14:8], row[16:15], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // nibble[3:0], wait_ms[9:4], zero pad
    output logic        m_tuser,   // reg_select
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cln_pkg::row_cfg_t   row_cfg;
    cln_pkg::ctrl_word_t cw;
    cln_pkg::kind_t      kind;

    logic                      busy_reg,  busy_next;
    logic [cln_pkg::STEP_W-1:0] step_reg, step_next;
    logic [7:0]                byte_reg,  byte_next;
    logic                      rs_reg,    rs_next;
    logic                      mvalid_reg, mvalid_next;
    logic [3:0]                nib_reg,   nib_next;
    logic [5:0]                wait_reg,  wait_next;
    logic                      mrs_reg,   mrs_next;
    logic                      mlast_reg, mlast_next;

    logic       accept;
    logic       out_free;
    logic [6:0] base;
    logic [6:0] addr;
    logic [6:0] col;
    logic [1:0] row;

    cln_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .row_cfg (row_cfg)
    );

    assign kind     = cln_pkg::kind_t'(s_tuser);
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign cw       = cln_pkg::ucode(step_reg);

    // Initialize ends with a move to column 0, row 0.
    assign col = (kind == cln_pkg::KIND_INIT) ? 7'd0 : s_tdata[14:8];
    assign row = (kind == cln_pkg::KIND_INIT) ? 2'd0 : s_tdata[16:15];

    always_comb begin
        case (row)
            2'd0:    base = row_cfg.first_row_base;
            2'd1:    base = row_cfg.second_row_base;
            default: base = 7'd0;
        endcase
    end

    assign addr = col + base;

    always_comb begin
        busy_next   = busy_reg;
        step_next   = step_reg;
        byte_next   = byte_reg;
        rs_next     = rs_reg;
        mvalid_next = mvalid_reg;
        nib_next    = nib_reg;
        wait_next   = wait_reg;
        mrs_next    = mrs_reg;
        mlast_next  = mlast_reg;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        if (accept) begin
            busy_next = 1'b1;
            rs_next   = (kind == cln_pkg::KIND_DATA);
            step_next = (kind == cln_pkg::KIND_INIT) ? cln_pkg::STEP_INIT
                                                     : cln_pkg::STEP_BYTE;
            case (kind)
                cln_pkg::KIND_CMD,
                cln_pkg::KIND_DATA: byte_next = s_tdata[7:0];
                default:            byte_next = {1'b1, addr};
            endcase
        end else if (busy_reg && out_free) begin
            mvalid_next = 1'b1;
            mrs_next    = rs_reg;
            mlast_next  = cw.last;
            wait_next   = (cw.data_nowait && rs_reg) ? 6'd0 : cw.wait_ms;
            case (cw.sel)
                cln_pkg::NIB_HIGH: nib_next = byte_reg[7:4];
                cln_pkg::NIB_LOW:  nib_next = byte_reg[3:0];
                default:           nib_next = cw.nib;
            endcase
            if (cw.last) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            step_reg   <= cln_pkg::STEP_BYTE;
            mvalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        rs_reg    <= rs_next;
        nib_reg   <= nib_next;
        wait_reg  <= wait_next;
        mrs_reg   <= mrs_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {6'd0, wait_reg, nib_reg};
    assign m_tuser  = mrs_reg;
    assign m_tlast  = mlast_reg;

endmodule

### rtl/cln_regs.sv
// ----------------------------------------------------------------------------
// cln_regs
// APB register file holding the display RAM base of the first two rows.
// ----------------------------------------------------------------------------
module cln_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cln_pkg::row_cfg_t  row_cfg
);

    logic [6:0] first_reg,  first_next;
    logic [6:0] second_reg, second_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        if (wr_en) begin
            if (paddr[2] == cln_pkg::REG_FIRST_ROW) begin
                first_next = pwdata[6:0];
            end else begin
                second_next = pwdata[6:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= cln_pkg::FIRST_ROW_RST;
            second_reg <= cln_pkg::SECOND_ROW_RST;
        end else begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign prdata = (paddr[2] == cln_pkg::REG_FIRST_ROW) ? {25'd0, first_reg}
                                                         : {25'd0, second_reg};

    assign row_cfg.first_row_base  = first_reg;
    assign row_cfg.second_row_base = second_reg;

endmodule

### rtl/cln_checker.sv
// ----------------------------------------------------------------------------
// cln_checker
// Port-level assertions for the LCD nibble sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module cln_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        pready
);

    // Stalled strobe holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled strobe changed");

    // An accepted request closes the input right after acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after accept");

    // A pending non-final strobe means a request is still in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open mid request");

    // A freshly issued final strobe finds the input open again and the APB port ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !$past(m_tvalid && !m_tready) |-> s_tready && pready)
        else $error("input closed after final strobe");

endmodule

bind char_lcd_nibble_sequencer_core cln_checker u_cln_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character LCD nibble sequencer.
// Requests go in on the s_ stream and strobes come out on the m_ stream. Each
// accepted request is expanded into its expected strobes, by a local model or
// from the byte given in the directed table. Every strobe that comes out is
// checked field by field, in order. The run starts with directed requests at
// the reset row bases. Random phases follow, each at its own row base setting.
// Both streams stall at random, except in a calm window of the second phase.
module tb;

    typedef struct {
        logic       rs;
        logic [3:0] nib;
        logic [5:0] wait_ms;
        logic       last;
    } strobe_t;

    typedef struct {
        cln_pkg::kind_t kind;
        logic [7:0]     value;
        logic [6:0]     column;
        logic [1:0]     row;
        logic           typed;     // expected byte given below
        logic [7:0]     exp_byte;
    } stim_row_t;

    localparam int N_DIR = 15;

    stim_row_t dir_tab [0:N_DIR-1] = '{
        '{cln_pkg::KIND_CMD,  8'h00, 7'd0,   2'd0, 1'b1, 8'h00},
        '{cln_pkg::KIND_CMD,  8'hFF, 7'd0,   2'd0, 1'b1, 8'hFF},
        '{cln_pkg::KIND_DATA, 8'h00, 7'd0,   2'd0, 1'b1, 8'h00},
        '{cln_pkg::KIND_DATA, 8'hFF, 7'd0,   2'd0, 1'b1, 8'hFF},
        '{cln_pkg::KIND_DATA, 8'hA5, 7'd127, 2'd3, 1'b1, 8'hA5},
        '{cln_pkg::KIND_CMD,  8'h5A, 7'd85,  2'd2, 1'b1, 8'h5A},
        '{cln_pkg::KIND_MOVE, 8'hFF, 7'd0,   2'd0, 1'b1, 8'h80},
        '{cln_pkg::KIND_MOVE, 8'h00, 7'd127, 2'd0, 1'b1, 8'hFF},
        '{cln_pkg::KIND_MOVE, 8'h00, 7'd0,   2'd1, 1'b1, 8'hC0},
        '{cln_pkg::KIND_MOVE, 8'h00, 7'd127, 2'd1, 1'b1, 8'hBF},
        '{cln_pkg::KIND_MOVE, 8'h00, 7'd5,   2'd2, 1'b1, 8'h85},
        '{cln_pkg::KIND_MOVE, 8'h00, 7'd127, 2'd3, 1'b1, 8'hFF},
        '{cln_pkg::KIND_INIT, 8'hFF, 7'd127, 2'd3, 1'b0, 8'h00},
        '{cln_pkg::KIND_INIT, 8'h00, 7'd0,   2'd0, 1'b0, 8'h00},
        '{cln_pkg::KIND_DATA, 8'h3C, 7'd44,  2'd1, 1'b0, 8'h00}
    };

    localparam logic [7:0] INIT_CMDS [0:5] = '{8'h28, 8'h0C, 8'h06, 8'h80, 8'h01, 8'h02};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // value[7:0], column[14:8], row[16:15], zero pad
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // nibble[3:0], wait_ms[9:4], zero pad
    logic        m_tuser;   // reg_select
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    strobe_t     pending_strobes [$];
    logic [6:0]  row0_base;
    logic [6:0]  row1_base;
    int          errors;
    logic        calm;

    char_lcd_nibble_sequencer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void push_strobe(logic rs, logic [3:0] nib, logic [5:0] w, logic last);
        strobe_t s;
        s.rs      = rs;
        s.nib     = nib;
        s.wait_ms = w;
        s.last    = last;
        pending_strobes.push_back(s);
    endfunction

    function automatic void push_byte(logic rs, logic [7:0] b, logic [5:0] w, logic last);
        push_strobe(rs, b[7:4], w, 1'b0);
        push_strobe(rs, b[3:0], 6'd0, last);
    endfunction

    function automatic logic [7:0] cursor_cmd(logic [6:0] column, logic [1:0] row);
        logic [6:0] base;
        base = 7'd0;
        if (row == 2'd0)
            base = row0_base;
        else if (row == 2'd1)
            base = row1_base;
        return {1'b1, column + base};
    endfunction

    function automatic void predict_strobes(cln_pkg::kind_t kind, logic [7:0] value,
                                            logic [6:0] column, logic [1:0] row);
        case (kind)
            cln_pkg::KIND_CMD:  push_byte(1'b0, value, 6'd2, 1'b1);
            cln_pkg::KIND_DATA: push_byte(1'b1, value, 6'd0, 1'b1);
            cln_pkg::KIND_MOVE: push_byte(1'b0, cursor_cmd(column, row), 6'd2, 1'b1);
            default: begin
                push_strobe(1'b0, 4'h3, 6'd50, 1'b0);
                push_strobe(1'b0, 4'h3, 6'd10, 1'b0);
                push_strobe(1'b0, 4'h3, 6'd10, 1'b0);
                push_strobe(1'b0, 4'h2, 6'd10, 1'b0);
                for (int i = 0; i < 6; i++)
                    push_byte(1'b0, INIT_CMDS[i], (i == 0) ? 6'd22 : 6'd12, 1'b0);
                push_byte(1'b0, cursor_cmd(7'd0, 2'd0), 6'd22, 1'b1);
            end
        endcase
    endfunction

    task automatic send_req(cln_pkg::kind_t kind, logic [7:0] value, logic [6:0] column,
                            logic [1:0] row);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, row, column, value};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_strobes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic sel, logic [6:0] base);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= ($urandom & ~32'h7F) | {25'd0, base};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == cln_pkg::REG_FIRST_ROW)
            row0_base = base;
        else
            row1_base = base;
    endtask

    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready <= calm || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_strobes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected strobe: rs=%0b nib=%h wait=%0d last=%0b",
                             m_tuser, m_tdata[3:0], m_tdata[9:4], m_tlast);
            end else begin
                strobe_t e;
                e = pending_strobes.pop_front();
                if (m_tuser !== e.rs || m_tdata[3:0] !== e.nib ||
                    m_tdata[9:4] !== e.wait_ms || m_tlast !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("strobe mismatch: exp rs=%0b nib=%h wait=%0d last=%0b,",
                                 e.rs, e.nib, e.wait_ms, e.last,
                                 " got rs=%0b nib=%h wait=%0d last=%0b",
                                 m_tuser, m_tdata[3:0], m_tdata[9:4], m_tlast);
                end
            end
        end
    end

    initial begin
        cln_pkg::kind_t k;
        logic [6:0]     cfg0;
        logic [6:0]     cfg1;
        int             pick;
        errors    = 0;
        calm      = 1'b0;
        row0_base = cln_pkg::FIRST_ROW_RST;
        row1_base = cln_pkg::SECOND_ROW_RST;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            send_req(dir_tab[i].kind, dir_tab[i].value, dir_tab[i].column, dir_tab[i].row);
            if (dir_tab[i].typed)
                push_byte(dir_tab[i].kind == cln_pkg::KIND_DATA, dir_tab[i].exp_byte,
                          (dir_tab[i].kind == cln_pkg::KIND_DATA) ? 6'd0 : 6'd2, 1'b1);
            else
                predict_strobes(dir_tab[i].kind, dir_tab[i].value,
                                dir_tab[i].column, dir_tab[i].row);
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin cfg0 = 7'd127; cfg1 = 7'd127; end
                1: begin cfg0 = 7'd0;   cfg1 = 7'd0;   end
                default: begin cfg0 = 7'($urandom); cfg1 = 7'($urandom); end
            endcase
            write_reg(cln_pkg::REG_FIRST_ROW, cfg0);
            write_reg(cln_pkg::REG_SECOND_ROW, cfg1);
            for (int n = 0; n < 92; n++) begin
                calm = (ph == 1) && (n >= 20) && (n < 80);
                pick = $urandom_range(99);
                if (pick < 30)
                    k = cln_pkg::KIND_CMD;
                else if (pick < 60)
                    k = cln_pkg::KIND_DATA;
                else if (pick < 90)
                    k = cln_pkg::KIND_MOVE;
                else
                    k = cln_pkg::KIND_INIT;
                send_req(k, 8'($urandom), 7'($urandom), 2'($urandom));
                predict_strobes(k, s_tdata[7:0], s_tdata[14:8], s_tdata[16:15]);
            end
            calm = 1'b0;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (pending_strobes.size() != 0)
            errors++;
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### char_lcd_nibble_sequencer_core.f
rtl/cln_pkg.sv
rtl/cln_regs.sv
rtl/char_lcd_nibble_sequencer_core.sv
rtl/cln_checker.sv
tb/tb.sv
